// ===== design/assert_macros.svh =====
// assertion macros for the disk seek scheduler
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define DSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== design/dss_pkg.sv =====
// shared types and constants of the disk seek scheduler
// no dependencies; used by dss_pick and disk_seek_scheduler
`default_nettype none

package dss_pkg;

  localparam int CYL_W     = 10;
  localparam int TOT_W     = 16;
  localparam int ALG_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_REQUESTS_DEF = 8;

  // algorithm codes
  localparam logic [ALG_W-1:0] ALG_FCFS  = 2'd0;
  localparam logic [ALG_W-1:0] ALG_SCAN  = 2'd1;
  localparam logic [ALG_W-1:0] ALG_CSCAN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_CYL    = 2'd2;

  // register reset values
  localparam logic [ALG_W-1:0] ALGORITHM_RST  = ALG_FCFS;
  localparam logic [CYL_W-1:0] HEAD_START_RST = 10'd55;
  localparam logic [CYL_W-1:0] END_CYL_RST    = 10'd200;

  // one candidate offered to the shared compare unit
  typedef struct packed {
    logic [CYL_W-1:0] value;
    logic [CYL_W-1:0] head;
    logic [CYL_W-1:0] best;
    logic             have_best;
    logic             below;
    logic             descend;
    logic             taken;
  } pick_req_t;

endpackage

`default_nettype wire

// ===== design/dss_pick.sv =====
// compare unit: decides whether a stored request beats the best candidate so far
// depends on dss_pkg
`default_nettype none

module dss_pick (
  input  dss_pkg::pick_req_t req_i,
  output logic               take_o
);

  logic eligible;
  logic better;

  // below the head for the low side, at or above it for the high side
  assign eligible = !req_i.taken &&
                    (req_i.below ? (req_i.value < req_i.head) : (req_i.value >= req_i.head));

  // strict compare keeps the earliest of equal values
  assign better = !req_i.have_best ||
                  (req_i.descend ? (req_i.value > req_i.best) : (req_i.value < req_i.best));

  assign take_o = eligible && better;

endmodule

`default_nettype wire

// ===== design/disk_seek_scheduler.sv =====
// Disk seek scheduler. Requests load one per cycle (start_i high, busy_o low); a request
// above the end cylinder is clamped to it, and one beyond MAX_REQUESTS is dropped. The
// request with last_request_i set starts the schedule and raises busy_o until the final move.
// FCFS moves stream one per cycle.
// SCAN and CSCAN pick each request move by a sweep of the request memory through one
// comparator, reading the memory through its single registered read port. The fixed moves
// to 0 and to the end cylinder need no sweep. Each move shows for one cycle with
// result_valid_o; the receiver cannot stall it.
// Depends on dss_pkg, dss_pick and assert_macros.svh.
`default_nettype none

module disk_seek_scheduler #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dss_pkg::CYL_W-1:0]     request_cylinder_i,
  input  logic                          last_request_i,
  output logic                          result_valid_o,
  output logic [dss_pkg::CYL_W-1:0]     target_cylinder_o,
  output logic [dss_pkg::CYL_W-1:0]     seek_distance_o,
  output logic [dss_pkg::TOT_W-1:0]     total_seek_o,
  output logic                          last_move_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dss_pkg::CYL_W-1:0]     cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef enum logic [2:0] {
    PH_FCFS,
    PH_BELOW_DESC,
    PH_ZERO,
    PH_UPPER_ASC,
    PH_END,
    PH_BELOW_ASC
  } phase_e;

  // configuration
  logic [dss_pkg::ALG_W-1:0] alg_q;
  logic [dss_pkg::CYL_W-1:0] head_q;
  logic [dss_pkg::CYL_W-1:0] disk_q;

  // control
  state_e                  state_q, state_d;
  phase_e                  phase_q, phase_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic                    have_q, have_d;
  logic [MAX_REQUESTS-1:0] done_q, done_d;
  logic                    rd_vld_q;
  logic                    valid_q;
  logic                    last_q;

  // payload
  logic [dss_pkg::CYL_W-1:0] mem_q [MAX_REQUESTS];
  logic [dss_pkg::CYL_W-1:0] rd_data_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic [dss_pkg::CYL_W-1:0] best_val_q, best_val_d;
  logic [IDX_W-1:0]          best_idx_q, best_idx_d;
  logic [dss_pkg::CYL_W-1:0] pos_q;
  logic [dss_pkg::CYL_W-1:0] tgt_q;
  logic [dss_pkg::CYL_W-1:0] dist_q;
  logic [dss_pkg::TOT_W-1:0] tot_q;

  logic                      accept;
  logic                      selecting;
  logic                      issue;
  logic                      sweep_done;
  logic                      take_raw;
  logic                      take;
  logic                      is_scan;
  logic                      emit;
  logic                      emit_last;
  logic                      finish;
  logic [dss_pkg::CYL_W-1:0] emit_tgt;
  logic [dss_pkg::CYL_W-1:0] req_clamped;
  logic [dss_pkg::CYL_W-1:0] move_dist;
  logic [dss_pkg::TOT_W:0]   tot_sum;
  dss_pkg::pick_req_t        pick_req;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign is_scan     = (alg_q == dss_pkg::ALG_SCAN);
  assign req_clamped = (request_cylinder_i > disk_q) ? disk_q : request_cylinder_i;

  assign selecting  = (phase_q == PH_BELOW_DESC) || (phase_q == PH_UPPER_ASC) ||
                      (phase_q == PH_BELOW_ASC);
  assign issue      = (state_q == S_RUN) && ((phase_q == PH_FCFS) || selecting) &&
                      (cnt_q < count_q);
  assign sweep_done = (cnt_q == count_q) && !rd_vld_q;

  always_comb begin
    pick_req.value     = rd_data_q;
    pick_req.head      = head_q;
    pick_req.best      = best_val_q;
    pick_req.have_best = have_q;
    pick_req.below     = (phase_q != PH_UPPER_ASC);
    pick_req.descend   = (phase_q == PH_BELOW_DESC);
    pick_req.taken     = done_q[rd_idx_q];
  end

  dss_pick u_pick (
    .req_i  (pick_req),
    .take_o (take_raw)
  );

  assign take = rd_vld_q && selecting && (state_q == S_RUN) && take_raw;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    count_d    = count_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    have_d     = have_q;
    done_d     = done_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_tgt   = '0;
    finish     = 1'b0;

    if (issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (take) begin
      have_d     = 1'b1;
      best_val_d = rd_data_q;
      best_idx_d = rd_idx_q;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (count_q < CNT_W'(MAX_REQUESTS)) begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_request_i) begin
            state_d = S_RUN;
            cnt_d   = '0;
            k_d     = '0;
            have_d  = 1'b0;
            done_d  = '0;
            case (alg_q)
              dss_pkg::ALG_SCAN:  phase_d = PH_BELOW_DESC;
              dss_pkg::ALG_CSCAN: phase_d = PH_UPPER_ASC;
              default:            phase_d = PH_FCFS;
            endcase
          end
        end
      end
      S_RUN: begin
        case (phase_q)
          PH_FCFS: begin
            if (rd_vld_q) begin
              emit      = 1'b1;
              emit_tgt  = rd_data_q;
              emit_last = (CNT_W'(rd_idx_q) + CNT_W'(1) == count_q);
            end
          end
          PH_ZERO: begin
            emit      = 1'b1;
            emit_tgt  = '0;
            emit_last = (k_q == count_q);
            cnt_d     = '0;
            phase_d   = is_scan ? PH_UPPER_ASC : PH_BELOW_ASC;
          end
          PH_END: begin
            emit     = 1'b1;
            emit_tgt = disk_q;
            cnt_d    = '0;
            phase_d  = PH_ZERO;
          end
          default: begin
            if (sweep_done) begin
              cnt_d  = '0;
              have_d = 1'b0;
              if (have_q) begin
                emit     = 1'b1;
                emit_tgt = best_val_q;
                // the low descending side of scan and the high side of circular scan
                // are always followed by a fixed move
                emit_last = ((phase_q == PH_BELOW_ASC) ||
                             ((phase_q == PH_UPPER_ASC) && is_scan)) &&
                            (k_q + CNT_W'(1) == count_q);
                k_d                = k_q + CNT_W'(1);
                done_d[best_idx_q] = 1'b1;
              end else begin
                case (phase_q)
                  PH_BELOW_DESC: phase_d = PH_ZERO;
                  PH_UPPER_ASC: begin
                    if (is_scan) begin
                      finish = 1'b1;
                    end else begin
                      phase_d = PH_END;
                    end
                  end
                  default: finish = 1'b1;
                endcase
              end
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase

    if ((emit && emit_last) || finish) begin
      state_d = S_IDLE;
      count_d = '0;
    end
  end

  // move arithmetic: distance and saturating running total
  assign move_dist = (emit_tgt >= pos_q) ? (emit_tgt - pos_q) : (pos_q - emit_tgt);
  assign tot_sum   = {1'b0, tot_q} + (dss_pkg::TOT_W + 1)'(move_dist);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q    <= dss_pkg::ALGORITHM_RST;
      head_q   <= dss_pkg::HEAD_START_RST;
      disk_q   <= dss_pkg::END_CYL_RST;
      state_q  <= S_IDLE;
      phase_q  <= PH_FCFS;
      count_q  <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      have_q   <= 1'b0;
      done_q   <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dss_pkg::REG_ALGORITHM:  alg_q  <= cfg_data_i[dss_pkg::ALG_W-1:0];
          dss_pkg::REG_HEAD_START: head_q <= cfg_data_i;
          dss_pkg::REG_END_CYL:    disk_q <= cfg_data_i;
          default: ;
        endcase
      end
      state_q  <= state_d;
      phase_q  <= phase_d;
      count_q  <= count_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      have_q   <= have_d;
      done_q   <= done_d;
      rd_vld_q <= issue;
      valid_q  <= emit;
      last_q   <= emit && emit_last;
    end
  end

  // request memory: one write port during loading, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && (count_q < CNT_W'(MAX_REQUESTS))) begin
      mem_q[count_q[IDX_W-1:0]] <= req_clamped;
    end
    if (issue) begin
      rd_data_q <= mem_q[cnt_q[IDX_W-1:0]];
      rd_idx_q  <= cnt_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    if (accept && last_request_i) begin
      pos_q <= head_q;
      tot_q <= '0;
    end else if (emit) begin
      pos_q  <= emit_tgt;
      tgt_q  <= emit_tgt;
      dist_q <= move_dist;
      tot_q  <= tot_sum[dss_pkg::TOT_W] ? '1 : tot_sum[dss_pkg::TOT_W-1:0];
    end
  end

  assign result_valid_o    = valid_q;
  assign target_cylinder_o = tgt_q;
  assign seek_distance_o   = dist_q;
  assign total_seek_o      = tot_q;
  assign last_move_o       = last_q;

`include "assert_macros.svh"

  `DSS_ASSERT_IMPL(a_more_moves_busy, clk_i, rst_ni,
                   result_valid_o && !last_move_o, busy_o)
  `DSS_ASSERT_IMPL(a_final_move_idle, clk_i, rst_ni,
                   result_valid_o && last_move_o, !busy_o)
  `DSS_ASSERT_IMPL(a_total_covers_move, clk_i, rst_ni,
                   result_valid_o, total_seek_o >= 16'(seek_distance_o))
  `DSS_ASSERT_NEXT(a_batch_end_starts, clk_i, rst_ni,
                   start_i && !busy_o && last_request_i, busy_o)

endmodule

`default_nettype wire
